[rtl/core/smh_pkg.sv]
// Shared types, constants and helper functions for the substring match highlighter.
// Used by smh_cell and substring_match_highlighter_core; depends on nothing else.
package smh_pkg;

    // Width of one Unicode codepoint.
    localparam int CP_W = 21;

    // ASCII letter range and the case offset.
    localparam logic [CP_W-1:0] ASCII_UPPER_A = 21'h41;
    localparam logic [CP_W-1:0] ASCII_UPPER_Z = 21'h5A;
    localparam logic [CP_W-1:0] ASCII_CASE_OFFSET = 21'h20;

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_EOL    = 2'd3
    } cmd_t;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic pat_append;  // write the pattern entry at index pattern length
        logic store;       // park a text character at the window tail
        logic emit;        // shift the window by one and take the new character
        logic pop;         // shift the window by one during an end-of-line flush
        logic match;       // full pattern occurrence found in this cycle
        logic nocase;      // compare with ASCII A-Z folded to lower case
    } cell_ctrl_t;

    function automatic logic is_upper(input logic [CP_W-1:0] c);
        return (c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z);
    endfunction

    function automatic logic [CP_W-1:0] fold_cp(input logic [CP_W-1:0] c, input logic en);
        return (en && is_upper(c)) ? c + ASCII_CASE_OFFSET : c;
    endfunction

endpackage

[rtl/core/smh_cell.sv]
// One cell of the match chain: one pattern codepoint and one window slot.
// Depends on smh_pkg for the control struct and the case folding function.
module smh_cell #(
    parameter int CNT_W = 6,
    parameter int IDX   = 0
) (
    input  logic                         clk,
    input  smh_pkg::cell_ctrl_t          ctrl,
    input  logic [CNT_W-1:0]             plen,
    input  logic [CNT_W-1:0]             count,
    input  logic [smh_pkg::CP_W-1:0]     cp,
    input  logic [smh_pkg::CP_W-1:0]     nbr_char,
    input  logic                         nbr_mark,
    output logic [smh_pkg::CP_W-1:0]     char_q,
    output logic                         mark_q,
    output logic                         eq
);

    logic [smh_pkg::CP_W-1:0] pat_reg;
    logic [smh_pkg::CP_W-1:0] char_reg;
    logic                     mark_reg;
    logic [smh_pkg::CP_W-1:0] char_next;
    logic                     mark_next;
    logic [smh_pkg::CP_W-1:0] cmp_char;
    logic                     is_tail;
    logic                     next_is_tail;
    logic                     in_pattern;

    // Position of this cell relative to the window tail and the pattern end.
    assign is_tail      = (count == CNT_W'(IDX));
    assign next_is_tail = (count == CNT_W'(IDX + 1));
    assign in_pattern   = (CNT_W'(IDX) < plen);

    // The tail slot sees the incoming character before it is stored.
    assign cmp_char = is_tail ? cp : char_reg;
    assign eq = !in_pattern ||
                (smh_pkg::fold_cp(pat_reg, ctrl.nocase) ==
                 smh_pkg::fold_cp(cmp_char, ctrl.nocase));

    // Window slot update: park at the tail, or take over the neighbor's slot.
    always_comb
    begin
        char_next = char_reg;
        mark_next = mark_reg;
        if (ctrl.store && is_tail)
        begin
            char_next = cp;
            mark_next = 1'b0;
        end
        else if (ctrl.emit)
        begin
            if (next_is_tail)
            begin
                char_next = cp;
                mark_next = ctrl.match;
            end
            else
            begin
                char_next = nbr_char;
                mark_next = nbr_mark | ctrl.match;
            end
        end
        else if (ctrl.pop)
        begin
            char_next = nbr_char;
            mark_next = nbr_mark;
        end
    end

    // Storage holds payload only, so it needs no reset.
    always_ff @(posedge clk)
    begin
        if (ctrl.pat_append && (plen == CNT_W'(IDX)))
        begin
            pat_reg <= cp;
        end
        char_reg <= char_next;
        mark_reg <= mark_next;
    end

    assign char_q = char_reg;
    assign mark_q = mark_reg;

endmodule

[rtl/core/substring_match_highlighter_core.sv]
// A text character leaves (pattern length - 1) text transfers after it arrives, registered
// in the cycle after the transfer that releases it; with an empty pattern it is registered in
// the cycle after its own transfer. Throughput: one item per cycle; end of line flushes the
// held characters at one per cycle, input stalled meanwhile, both while the output is not
// stalled. Reset clears the pattern length, the window count and the flush flag and sets smart
// case to 1; pattern and window storage are not cleared, as only written slots are ever read.
module substring_match_highlighter_core #(
    parameter int PATTERN_MAX = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   cmd,
    input  logic [smh_pkg::CP_W-1:0]     codepoint,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [smh_pkg::CP_W-1:0]     text_char,
    output logic                         highlighted,
    output logic                         line_last
);

    localparam int CNT_W = $clog2(PATTERN_MAX + 1);

    logic                      fold_en_reg;
    logic [CNT_W-1:0]          plen_reg;
    logic [CNT_W-1:0]          plen_next;
    logic                      has_upper_reg;
    logic                      has_upper_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      flush_reg;
    logic                      flush_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [smh_pkg::CP_W-1:0]  out_char_reg;
    logic [smh_pkg::CP_W-1:0]  out_char_next;
    logic                      out_mark_reg;
    logic                      out_mark_next;
    logic                      out_last_reg;
    logic                      out_last_next;

    logic                      out_free;
    logic                      in_accept;
    logic                      do_pop;
    logic                      match;
    smh_pkg::cmd_t             cmd_code;
    smh_pkg::cell_ctrl_t       ctrl;

    logic [smh_pkg::CP_W-1:0]  win_char [PATTERN_MAX];
    logic                      win_mark [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]    cell_eq;

    // Handshake: the output slot is free when empty or drained this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = flush_reg || !out_free;
    assign in_accept = in_valid && !in_stall;
    assign cmd_code  = smh_pkg::cmd_t'(cmd);

    // A full occurrence needs every cell inside the pattern to agree.
    assign match = &cell_eq;

    // Sequencer: decode the transfer and decide what the chain does.
    always_comb
    begin
        ctrl           = '0;
        ctrl.match     = match;
        ctrl.nocase    = fold_en_reg && !has_upper_reg;
        plen_next      = plen_reg;
        has_upper_next = has_upper_reg;
        count_next     = count_reg;
        flush_next     = flush_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_char_next  = out_char_reg;
        out_mark_next  = out_mark_reg;
        out_last_next  = out_last_reg;
        do_pop         = 1'b0;

        if (in_accept)
        begin
            unique case (cmd_code)
                smh_pkg::CMD_CLEAR:
                begin
                    if (count_reg == '0)
                    begin
                        plen_next      = '0;
                        has_upper_next = 1'b0;
                    end
                end
                smh_pkg::CMD_APPEND:
                begin
                    if ((count_reg == '0) && (plen_reg < CNT_W'(PATTERN_MAX)))
                    begin
                        ctrl.pat_append = 1'b1;
                        plen_next       = plen_reg + 1'b1;
                        has_upper_next  = has_upper_reg | smh_pkg::is_upper(codepoint);
                    end
                end
                smh_pkg::CMD_TEXT:
                begin
                    if (plen_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = codepoint;
                        out_mark_next  = 1'b0;
                        out_last_next  = 1'b0;
                    end
                    else if (count_reg == plen_reg - 1'b1)
                    begin
                        // Window is full: check, release the oldest, shift.
                        ctrl.emit      = 1'b1;
                        out_valid_next = 1'b1;
                        out_last_next  = 1'b0;
                        if (count_reg == '0)
                        begin
                            out_char_next = codepoint;
                            out_mark_next = match;
                        end
                        else
                        begin
                            out_char_next = win_char[0];
                            out_mark_next = win_mark[0] | match;
                        end
                    end
                    else
                    begin
                        ctrl.store = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                smh_pkg::CMD_EOL:
                begin
                    do_pop = (count_reg != '0);
                end
                default:
                begin
                end
            endcase
        end
        else if (flush_reg && out_free)
        begin
            do_pop = 1'b1;
        end

        // Flush step: release the oldest held character.
        if (do_pop)
        begin
            ctrl.pop       = 1'b1;
            out_valid_next = 1'b1;
            out_char_next  = win_char[0];
            out_mark_next  = win_mark[0];
            out_last_next  = (count_reg == CNT_W'(1));
            count_next     = count_reg - 1'b1;
            flush_next     = (count_reg > CNT_W'(1));
        end
    end

    // Control state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_en_reg    <= 1'b1;
            plen_reg       <= '0;
            has_upper_reg  <= 1'b0;
            count_reg      <= '0;
            flush_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fold_en_reg <= cfg_wdata;
            end
            plen_reg      <= plen_next;
            has_upper_reg <= has_upper_next;
            count_reg     <= count_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_mark_reg <= out_mark_next;
        out_last_reg <= out_last_next;
    end

    // The chain of cells; each takes its right neighbor's slot on a shift.
    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        logic [smh_pkg::CP_W-1:0] nbr_char;
        logic                     nbr_mark;

        if (k + 1 < PATTERN_MAX)
        begin : g_nbr
            assign nbr_char = win_char[k + 1];
            assign nbr_mark = win_mark[k + 1];
        end
        else
        begin : g_end
            assign nbr_char = '0;
            assign nbr_mark = 1'b0;
        end

        smh_cell #(
            .CNT_W (CNT_W),
            .IDX   (k)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .plen     (plen_reg),
            .count    (count_reg),
            .cp       (codepoint),
            .nbr_char (nbr_char),
            .nbr_mark (nbr_mark),
            .char_q   (win_char[k]),
            .mark_q   (win_mark[k]),
            .eq       (cell_eq[k])
        );
    end

    assign out_valid   = out_valid_reg;
    assign text_char   = out_char_reg;
    assign highlighted = out_mark_reg;
    assign line_last   = out_last_reg;

`ifndef SYNTHESIS
    // The window always holds fewer characters than the pattern length.
    a_count_below_plen: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (count_reg < plen_reg))
        else $error("window count not below pattern length");

    // A flush only runs while characters remain in the window.
    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> (count_reg != '0))
        else $error("flush with empty window");

    // Once the last character of a line is out, the flush is over.
    a_last_ends_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> !flush_reg)
        else $error("flush still running after line end");

    // An accepted append into an idle, non-full pattern grows it by one.
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (cmd_code == smh_pkg::CMD_APPEND) && (count_reg == '0) &&
         (plen_reg < CNT_W'(PATTERN_MAX)))
        |=> (plen_reg == $past(plen_reg) + 1'b1))
        else $error("pattern append lost");
`endif

endmodule
